// ===== sv/lsfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, state type and angle helper for the scan frame parser.
// No dependencies.
package lsfp_pkg;

   localparam int MAX_POINTS_DEF   = 40;
   localparam int HEADER_BYTES_DEF = 10;

   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;

   // one revolution in 1/64 degree
   localparam int REV_X64 = 23040;
   // angle difference magnitude fits 16 bits
   localparam int DIV_W = 16;

   localparam logic [1:0] KIND_POINT  = 2'd0;
   localparam logic [1:0] KIND_COUNT  = 2'd1;
   localparam logic [1:0] KIND_CKSUM  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN,
      ST_DIV,
      ST_RD1,
      ST_RD2,
      ST_EMIT
   } state_type;

   // a is known to lie within one revolution either side of [0, REV_X64)
   function automatic logic [14:0] wrap_angle(input logic signed [16:0] a);
      logic signed [16:0] r;
      begin
         r = a;
         if (a < 0) begin
            r = a + 17'sd23040;
         end else if (a >= 17'sd23040) begin
            r = a - 17'sd23040;
         end
         wrap_angle = r[14:0];
      end
   endfunction

endpackage

// ===== sv/lsfp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lsfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 130
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lidar_scan_frame_parser.sv =====
`timescale 1ns / 1ps
// Scan frame parser top level: byte sync, frame store, checksum, angle divide, point emit.
// Depends on lsfp_pkg and lsfp_ram.
//
// Takes one byte per cycle while a frame is being received, unless a result item is held by
// the stalled result side; the header and points are written to a frame RAM and the two XOR
// checksums are accumulated on the fly. After the final byte of a frame the input stalls for
// the checksum verdict, then (good frame) the bit-serial step division, then for each point
// the two reads of the single RAM read port it needs and its emit, which waits while the
// result side stalls. A bad count or bad checksum gives one error item and no divide.
module lidar_scan_frame_parser #(
   parameter int MAX_POINTS   = lsfp_pkg::MAX_POINTS_DEF,
   parameter int HEADER_BYTES = lsfp_pkg::HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [14:0] rsp_angle,
   output logic [13:0] rsp_distance,
   output logic [7:0]  rsp_quality,
   output logic        rsp_rotation_start,
   output logic [6:0]  rsp_speed_tenths_hz,
   output logic        rsp_last
);

   localparam int STORE_DEPTH = HEADER_BYTES + 3 * MAX_POINTS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int POS_W       = $clog2(STORE_DEPTH + 1);
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);
   localparam int DCNT_W      = $clog2(lsfp_pkg::DIV_W);

   lsfp_pkg::state_type state_ff, state_in;

   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  end_pos_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [1:0]        ph_ff;
   logic [7:0]        ce_ff, co_ff;
   logic [7:0]        spd_byte_ff, st_lo_ff, st_hi_ff, en_lo_ff, en_hi_ff, ck_even_ff, ck_odd_ff;
   logic [14:0]       prev_ff;
   logic [6:0]        speed_ff;
   logic              rot_flag_ff;
   logic signed [16:0] acc_ff, step_ff;
   logic              neg_ff, one_pt_ff;
   logic [lsfp_pkg::DIV_W-1:0] dq_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]        b1_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff;
   logic [14:0]       rsp_angle_ff;
   logic [13:0]       rsp_dist_ff;
   logic [7:0]        rsp_qual_ff;
   logic              rsp_rot_ff;
   logic [6:0]        rsp_speed_ff;
   logic              rsp_last_ff;

   logic              out_free, accept;
   logic              rsp_load;
   logic [7:0]        c;
   logic [POS_W-1:0]  pos_nx;
   logic              cnt_bad, frame_end, ck_ok;
   logic [14:0]       st_raw, en_raw;
   logic signed [16:0] start_s, diff;
   logic [CNT_W-1:0]  dvs;
   logic [CNT_W:0]    rem_sh;
   logic              qbit;
   logic [lsfp_pkg::DIV_W-1:0] q_nx;
   logic              last_pt;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              wr_en;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign c         = req_rx_byte;
   assign accept    = req_valid && !req_stall;
   assign pos_nx    = pos_ff + POS_W'(1);
   assign cnt_bad   = (c == 8'd0) || (c > 8'(MAX_POINTS));
   assign frame_end = (pos_ff >= POS_W'(HEADER_BYTES - 1)) && (pos_nx == end_pos_ff);
   assign ck_ok     = (ce_ff == ck_even_ff) && (co_ff == ck_odd_ff);
   assign st_raw    = {st_hi_ff, st_lo_ff[7:1]};
   assign en_raw    = {en_hi_ff, en_lo_ff[7:1]};
   assign start_s   = (en_raw < st_raw) ? ($signed({2'b00, st_raw}) - 17'sd23040)
                                        : $signed({2'b00, st_raw});
   assign diff      = $signed({2'b00, en_raw}) - start_s;
   assign dvs       = cnt_ff - CNT_W'(1);
   assign rem_sh    = {rem_ff, dq_ff[lsfp_pkg::DIV_W-1]};
   assign qbit      = rem_sh >= {1'b0, dvs};
   assign q_nx      = {dq_ff[lsfp_pkg::DIV_W-2:0], qbit};
   assign last_pt   = idx_ff == dvs;
   assign wr_en     = accept && (pos_ff >= POS_W'(2)) && (pos_ff < POS_W'(STORE_DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lsfp_pkg::ST_IDLE: begin
            if (accept && pos_ff >= POS_W'(2) && frame_end) begin
               state_in = lsfp_pkg::ST_FIN;
            end
         end
         lsfp_pkg::ST_FIN: begin
            if (!ck_ok) begin
               if (out_free) begin
                  state_in = lsfp_pkg::ST_IDLE;
               end
            end else begin
               state_in = lsfp_pkg::ST_DIV;
            end
         end
         lsfp_pkg::ST_DIV: begin
            if (dcnt_ff == DCNT_W'(lsfp_pkg::DIV_W - 1)) begin
               state_in = lsfp_pkg::ST_RD1;
            end
         end
         lsfp_pkg::ST_RD1: state_in = lsfp_pkg::ST_RD2;
         lsfp_pkg::ST_RD2: state_in = lsfp_pkg::ST_EMIT;
         lsfp_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = last_pt ? lsfp_pkg::ST_IDLE : lsfp_pkg::ST_RD1;
            end
         end
         default: state_in = lsfp_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      rd_addr   = addr_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         lsfp_pkg::ST_IDLE: begin
            req_stall = !out_free;
            rsp_load  = req_valid && out_free && (pos_ff == POS_W'(3)) && cnt_bad;
         end
         lsfp_pkg::ST_FIN:  rsp_load = !ck_ok && out_free;
         lsfp_pkg::ST_RD1:  rd_addr = addr_ff;
         lsfp_pkg::ST_RD2:  rd_addr = addr_ff + ADDR_W'(1);
         lsfp_pkg::ST_EMIT: begin
            rd_addr  = addr_ff + ADDR_W'(1);
            rsp_load = out_free;
         end
         default:           rd_addr = addr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsfp_pkg::ST_IDLE;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         prev_ff      <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            lsfp_pkg::ST_IDLE: begin
               if (accept) begin
                  if (pos_ff == '0) begin
                     if (c == lsfp_pkg::SYNC_FIRST) begin
                        pos_ff <= POS_W'(1);
                     end
                  end else if (pos_ff == POS_W'(1)) begin
                     if (c == lsfp_pkg::SYNC_SECOND) begin
                        pos_ff <= POS_W'(2);
                     end else if (c != lsfp_pkg::SYNC_FIRST) begin
                        pos_ff <= '0;
                     end
                  end else begin
                     if (pos_ff == POS_W'(3) && cnt_bad) begin
                        pos_ff <= '0;
                     end else if (frame_end || pos_nx >= POS_W'(STORE_DEPTH)) begin
                        pos_ff <= '0;
                     end else begin
                        pos_ff <= pos_nx;
                     end
                     if (pos_ff == POS_W'(3) && !cnt_bad) begin
                        cnt_ff <= c[CNT_W-1:0];
                     end
                  end
               end
            end
            lsfp_pkg::ST_FIN: begin
               if (ck_ok) begin
                  if (spd_byte_ff[0]) begin
                     speed_ff <= spd_byte_ff[7:1];
                  end
                  prev_ff <= lsfp_pkg::wrap_angle(start_s);
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         lsfp_pkg::ST_IDLE: begin
            if (accept) begin
               if (pos_ff == POS_W'(1) && c == lsfp_pkg::SYNC_SECOND) begin
                  ce_ff <= lsfp_pkg::SYNC_FIRST;
                  co_ff <= lsfp_pkg::SYNC_SECOND;
                  ph_ff <= 2'd0;
               end
               if (pos_ff >= POS_W'(2)) begin
                  if (pos_ff < POS_W'(HEADER_BYTES)) begin
                     case (pos_ff[3:0])
                        4'd2: begin spd_byte_ff <= c; ce_ff <= ce_ff ^ c; end
                        4'd3: begin co_ff <= co_ff ^ c;
                              end_pos_ff <= POS_W'(HEADER_BYTES) + POS_W'(c) * POS_W'(3); end
                        4'd4: begin st_lo_ff <= c; ce_ff <= ce_ff ^ c; end
                        4'd5: begin st_hi_ff <= c; co_ff <= co_ff ^ c; end
                        4'd6: begin en_lo_ff <= c; ce_ff <= ce_ff ^ c; end
                        4'd7: begin en_hi_ff <= c; co_ff <= co_ff ^ c; end
                        4'd8: ck_even_ff <= c;
                        4'd9: ck_odd_ff <= c;
                        default: ;
                     endcase
                  end else begin
                     // points: b0 and b1 go to the even sum, b2 to the odd sum
                     if (ph_ff == 2'd2) begin
                        co_ff <= co_ff ^ c;
                        ph_ff <= 2'd0;
                     end else begin
                        ce_ff <= ce_ff ^ c;
                        ph_ff <= ph_ff + 2'd1;
                     end
                  end
               end
               if (pos_ff == POS_W'(3) && cnt_bad) begin
                  rsp_kind_ff  <= lsfp_pkg::KIND_COUNT;
                  rsp_angle_ff <= '0;
                  rsp_dist_ff  <= '0;
                  rsp_qual_ff  <= '0;
                  rsp_rot_ff   <= 1'b0;
                  rsp_speed_ff <= speed_ff;
                  rsp_last_ff  <= 1'b1;
               end
            end
         end
         lsfp_pkg::ST_FIN: begin
            rsp_kind_ff  <= lsfp_pkg::KIND_CKSUM;
            rsp_angle_ff <= '0;
            rsp_dist_ff  <= '0;
            rsp_qual_ff  <= '0;
            rsp_rot_ff   <= 1'b0;
            rsp_speed_ff <= speed_ff;
            rsp_last_ff  <= 1'b1;
            rot_flag_ff  <= lsfp_pkg::wrap_angle(start_s) < prev_ff;
            acc_ff       <= start_s;
            neg_ff       <= diff[16];
            dq_ff        <= diff[16] ? lsfp_pkg::DIV_W'(-diff) : diff[lsfp_pkg::DIV_W-1:0];
            rem_ff       <= '0;
            dcnt_ff      <= '0;
            one_pt_ff    <= cnt_ff == CNT_W'(1);
            idx_ff       <= '0;
            addr_ff      <= ADDR_W'(HEADER_BYTES + 1);
         end
         lsfp_pkg::ST_DIV: begin
            dq_ff   <= q_nx;
            rem_ff  <= qbit ? CNT_W'(rem_sh - {1'b0, dvs}) : rem_sh[CNT_W-1:0];
            dcnt_ff <= dcnt_ff + DCNT_W'(1);
            if (one_pt_ff) begin
               step_ff <= '0;
            end else begin
               step_ff <= neg_ff ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
            end
         end
         lsfp_pkg::ST_RD2: b1_ff <= rd_data;
         lsfp_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_kind_ff  <= lsfp_pkg::KIND_POINT;
               rsp_angle_ff <= lsfp_pkg::wrap_angle(acc_ff);
               rsp_dist_ff  <= {rd_data, b1_ff[7:2]};
               rsp_qual_ff  <= {b1_ff[1:0], rd_data[7:2]};
               rsp_rot_ff   <= (idx_ff == '0) && rot_flag_ff;
               rsp_speed_ff <= speed_ff;
               rsp_last_ff  <= last_pt;
               acc_ff       <= acc_ff + step_ff;
               idx_ff       <= idx_ff + CNT_W'(1);
               addr_ff      <= addr_ff + ADDR_W'(3);
            end
         end
         default: ;
      endcase
   end

   lsfp_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[ADDR_W-1:0]),
      .wr_data (c),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_angle           = rsp_angle_ff;
   assign rsp_distance        = rsp_dist_ff;
   assign rsp_quality         = rsp_qual_ff;
   assign rsp_rotation_start  = rsp_rot_ff;
   assign rsp_speed_tenths_hz = rsp_speed_ff;
   assign rsp_last            = rsp_last_ff;

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != lsfp_pkg::ST_IDLE |-> req_stall)
      else $error("input taken while frame work in progress");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != lsfp_pkg::KIND_POINT |-> rsp_last_ff)
      else $error("error item not marked last");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == lsfp_pkg::KIND_POINT |-> rsp_angle_ff < 15'd23040)
      else $error("angle outside one revolution");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == lsfp_pkg::ST_DIV |=>
         state_ff == lsfp_pkg::ST_DIV || state_ff == lsfp_pkg::ST_RD1)
      else $error("divider left to wrong state");
`endif

endmodule
